// File: rtl/nearest_neighbor_area_scaler_assert.svh
// assertion macros shared by the scaler's rtl modules
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef NEAREST_NEIGHBOR_AREA_SCALER_ASSERT_SVH
`define NEAREST_NEIGHBOR_AREA_SCALER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define NNAS_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nnas: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define NNAS_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nnas: next-cycle check failed");

`endif

// File: rtl/nnas_pkg.sv
// shared types and constants of the nearest neighbour area scaler
// no dependencies
package nnas_pkg;

	localparam int COORD_W = 16;
	localparam int COLOR_W = 32;
	localparam int ADDR_W  = 22;
	localparam int CFG_W   = 12;
	localparam int APB_W   = 32;
	localparam int PADDR_W = 4;

	// configuration register indexes (byte address / 4)
	typedef enum logic [1:0] {
		CFG_SRC_WIDTH  = 2'd0,
		CFG_SRC_HEIGHT = 2'd1,
		CFG_DST_WIDTH  = 2'd2,
		CFG_DST_HEIGHT = 2'd3
	} nnas_cfg_idx_t;

	// controller states
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CHECK = 7'b0000010,
		S_DIVS  = 7'b0000100,
		S_DIVW  = 7'b0001000,
		S_SPAN  = 7'b0010000,
		S_BASE  = 7'b0100000,
		S_EMIT  = 7'b1000000
	} nnas_state_t;

	// controller to datapath
	typedef struct packed {
		logic ready;
		logic check;
		logic div_start;
		logic span;
		logic base;
		logic emit;
	} nnas_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic take;
		logic on_screen;
		logic div_busy;
		logic span_empty;
		logic out_free;
		logic emit_last;
	} nnas_status_t;

endpackage

// File: rtl/nnas_pixel_if.sv
// source pixel channel: valid/ready handshake with the pixel item
// depends on nnas_pkg
interface nnas_pixel_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 first_of_area;
	logic signed [nnas_pkg::COORD_W-1:0]  area_left;
	logic signed [nnas_pkg::COORD_W-1:0]  area_top;
	logic signed [nnas_pkg::COORD_W-1:0]  area_right;
	logic        [nnas_pkg::COLOR_W-1:0]  pixel_color;

	modport source (
		output valid, first_of_area, area_left, area_top, area_right, pixel_color,
		input  ready
	);
	modport sink (
		input  valid, first_of_area, area_left, area_top, area_right, pixel_color,
		output ready
	);
endinterface

// File: rtl/nnas_write_if.sv
// framebuffer write channel: valid/ready handshake with the write item
// depends on nnas_pkg
interface nnas_write_if;
	logic                          valid;
	logic                          ready;
	logic [nnas_pkg::ADDR_W-1:0]   write_address;
	logic [nnas_pkg::COLOR_W-1:0]  write_color;
	logic                          last_write;

	modport source (
		output valid, write_address, write_color, last_write,
		input  ready
	);
	modport sink (
		input  valid, write_address, write_color, last_write,
		output ready
	);
endinterface

// File: rtl/nnas_div.sv
// restoring divider, one quotient bit per cycle
// no dependencies; the caller guarantees the quotient fits in DIM_W bits
module nnas_div #(
	parameter int DIM_W = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [2*DIM_W-1:0]   dividend,
	input  logic [DIM_W-1:0]     divisor,
	output logic [DIM_W-1:0]     quotient,
	output logic                 busy
);
	localparam int STEP_W = $clog2(DIM_W + 1);

	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic [DIM_W-1:0]  rem_q;
	logic [DIM_W-1:0]  quo_q;
	logic [DIM_W:0]    trial;
	logic [DIM_W:0]    diff;
	logic              fits;

	// shift in the next dividend bit and try a subtract
	always_comb begin
		trial = {rem_q, quo_q[DIM_W-1]};
		diff  = trial - {1'b0, divisor};
		fits  = trial >= {1'b0, divisor};
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(DIM_W);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1))
				busy_q <= 1'b0;
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[2*DIM_W-1:DIM_W];
			quo_q <= dividend[DIM_W-1:0];
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
			quo_q <= {quo_q[DIM_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign busy     = busy_q;

endmodule

// File: rtl/nnas_ctrl.sv
// controller of the scaler: sequences check, divide, span and emission
// depends on nnas_pkg and nearest_neighbor_area_scaler_assert.svh
`include "nearest_neighbor_area_scaler_assert.svh"

module nnas_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  nnas_pkg::nnas_status_t st,
	output nnas_pkg::nnas_cmd_t    cmd
);
	nnas_pkg::nnas_state_t state_q;
	nnas_pkg::nnas_state_t state_d;
	logic                  emit_done;

	assign emit_done = st.out_free && st.emit_last;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			nnas_pkg::S_IDLE: begin
				cmd.ready = 1'b1;
				if (st.take)
					state_d = nnas_pkg::S_CHECK;
			end
			nnas_pkg::S_CHECK: begin
				cmd.check = 1'b1;
				state_d = st.on_screen ? nnas_pkg::S_DIVS : nnas_pkg::S_IDLE;
			end
			nnas_pkg::S_DIVS: begin
				cmd.div_start = 1'b1;
				state_d = nnas_pkg::S_DIVW;
			end
			nnas_pkg::S_DIVW: begin
				if (!st.div_busy)
					state_d = nnas_pkg::S_SPAN;
			end
			nnas_pkg::S_SPAN: begin
				cmd.span = 1'b1;
				state_d = nnas_pkg::S_BASE;
			end
			nnas_pkg::S_BASE: begin
				cmd.base = 1'b1;
				state_d = st.span_empty ? nnas_pkg::S_IDLE : nnas_pkg::S_EMIT;
			end
			nnas_pkg::S_EMIT: begin
				cmd.emit = 1'b1;
				if (st.out_free && st.emit_last)
					state_d = nnas_pkg::S_IDLE;
			end
			default: begin
				state_d = nnas_pkg::S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= nnas_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	// the dividers only run while the controller waits for them
	`NNAS_ASSERT_SAME(a_div_busy_in_wait, st.div_busy, state_q == nnas_pkg::S_DIVW)
	// emission only ends on the last write of the item
	`NNAS_ASSERT_NEXT(a_emit_holds, state_q == nnas_pkg::S_EMIT && !emit_done, state_q == nnas_pkg::S_EMIT)

endmodule

// File: rtl/nnas_dpath.sv
// datapath of the scaler: position counters, span dividers, address stepping,
// output register; depends on nnas_pkg, nnas_div, the channel interfaces
// and nearest_neighbor_area_scaler_assert.svh
`include "nearest_neighbor_area_scaler_assert.svh"

module nnas_dpath #(
	parameter int MAX_UPSCALE = 8,
	parameter int DIM_W       = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  nnas_pkg::nnas_cmd_t    cmd,
	output nnas_pkg::nnas_status_t st,
	input  logic [DIM_W-1:0]       src_width,
	input  logic [DIM_W-1:0]       src_height,
	input  logic [DIM_W-1:0]       dst_width,
	input  logic [DIM_W-1:0]       dst_height,
	nnas_pixel_if.sink             pixel,
	nnas_write_if.source           wr
);
	localparam int CW    = nnas_pkg::COORD_W;
	localparam int AW    = nnas_pkg::ADDR_W;
	localparam int DV_W  = 2 * DIM_W;
	localparam int CNT_W = $clog2(MAX_UPSCALE + 1);

	// position state
	logic [CW-1:0] cur_col_q, cur_row_q;
	logic [CW-1:0] col_eff, row_eff;
	logic [CW-1:0] col_q, row_q;
	logic [nnas_pkg::COLOR_W-1:0] color_q;
	logic take;

	// span calculation
	logic [DIM_W-1:0] sx, sy;
	logic [DV_W-1:0]  x_lo_c, x_hi_c, y_lo_c, y_hi_c;
	logic [DV_W-1:0]  x_lo_q, x_hi_q, y_lo_q, y_hi_q;
	logic [DIM_W-1:0] qx_lo, qx_hi, qy_lo, qy_hi;
	logic [3:0]       div_busy;
	logic [DIM_W-1:0] x_end, y_end, x_diff, y_diff;
	logic [CNT_W-1:0] x_cnt, y_cnt;
	logic [CNT_W-1:0] nx_q, ny_q;
	logic [DIM_W-1:0] x0_q, y0_q;

	// emission
	logic [AW-1:0]    base_c;
	logic [AW-1:0]    row_addr_q, col_addr_q;
	logic [CNT_W-1:0] i_q, j_q;
	logic             row_end, emit_last, out_free, load;
	logic             wr_valid_q;
	logic [AW-1:0]    wr_addr_q;
	logic [nnas_pkg::COLOR_W-1:0] wr_color_q;
	logic             wr_last_q;

	// input handshake and effective position of the incoming pixel
	assign pixel.ready = cmd.ready;
	assign take        = pixel.valid && cmd.ready;
	assign col_eff     = pixel.first_of_area ? pixel.area_left : cur_col_q;
	assign row_eff     = pixel.first_of_area ? pixel.area_top : cur_row_q;

	// raster stepping with wrap after the right edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
		end else if (take) begin
			if ($signed(col_eff) >= $signed(pixel.area_right)) begin
				cur_col_q <= pixel.area_left;
				cur_row_q <= CW'(row_eff + 1'b1);
			end else begin
				cur_col_q <= CW'(col_eff + 1'b1);
				cur_row_q <= row_eff;
			end
		end
	end

	// pixel being worked on
	always_ff @(posedge clk) begin
		if (take) begin
			col_q   <= col_eff;
			row_q   <= row_eff;
			color_q <= pixel.pixel_color;
		end
	end

	// ceil dividends: s*dst + src - 1 and (s+1)*dst + src - 1
	always_comb begin
		sx     = col_q[DIM_W-1:0];
		sy     = row_q[DIM_W-1:0];
		x_lo_c = DV_W'(sx) * DV_W'(dst_width) + DV_W'(src_width) - DV_W'(1);
		x_hi_c = x_lo_c + DV_W'(dst_width);
		y_lo_c = DV_W'(sy) * DV_W'(dst_height) + DV_W'(src_height) - DV_W'(1);
		y_hi_c = y_lo_c + DV_W'(dst_height);
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			x_lo_q <= x_lo_c;
			x_hi_q <= x_hi_c;
			y_lo_q <= y_lo_c;
			y_hi_q <= y_hi_c;
		end
	end

	// four dividers run side by side
	nnas_div #(.DIM_W(DIM_W)) u_div_xlo (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .dividend(x_lo_q),
		.divisor(src_width), .quotient(qx_lo), .busy(div_busy[0])
	);
	nnas_div #(.DIM_W(DIM_W)) u_div_xhi (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .dividend(x_hi_q),
		.divisor(src_width), .quotient(qx_hi), .busy(div_busy[1])
	);
	nnas_div #(.DIM_W(DIM_W)) u_div_ylo (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .dividend(y_lo_q),
		.divisor(src_height), .quotient(qy_lo), .busy(div_busy[2])
	);
	nnas_div #(.DIM_W(DIM_W)) u_div_yhi (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .dividend(y_hi_q),
		.divisor(src_height), .quotient(qy_hi), .busy(div_busy[3])
	);

	// span length per axis, capped at the upscale limit
	always_comb begin
		x_end  = (qx_hi > dst_width) ? dst_width : qx_hi;
		y_end  = (qy_hi > dst_height) ? dst_height : qy_hi;
		x_diff = x_end - qx_lo;
		y_diff = y_end - qy_lo;
		if (x_end <= qx_lo)
			x_cnt = '0;
		else if (x_diff > DIM_W'(MAX_UPSCALE))
			x_cnt = CNT_W'(MAX_UPSCALE);
		else
			x_cnt = CNT_W'(x_diff);
		if (y_end <= qy_lo)
			y_cnt = '0;
		else if (y_diff > DIM_W'(MAX_UPSCALE))
			y_cnt = CNT_W'(MAX_UPSCALE);
		else
			y_cnt = CNT_W'(y_diff);
	end

	always_ff @(posedge clk) begin
		if (cmd.span) begin
			nx_q <= x_cnt;
			ny_q <= y_cnt;
			x0_q <= qx_lo;
			y0_q <= qy_lo;
		end
	end

	// first destination address of the span
	assign base_c = AW'(DV_W'(y0_q) * DV_W'(dst_width)) + AW'(x0_q);

	// write stepping: columns inner, rows outer
	assign out_free  = !wr_valid_q || wr.ready;
	assign load      = cmd.emit && out_free;
	assign row_end   = CNT_W'(i_q + 1'b1) == nx_q;
	assign emit_last = row_end && (CNT_W'(j_q + 1'b1) == ny_q);

	always_ff @(posedge clk) begin
		if (cmd.base) begin
			row_addr_q <= base_c;
			col_addr_q <= base_c;
			i_q        <= '0;
			j_q        <= '0;
		end else if (load) begin
			if (row_end) begin
				i_q        <= '0;
				j_q        <= CNT_W'(j_q + 1'b1);
				row_addr_q <= row_addr_q + AW'(dst_width);
				col_addr_q <= row_addr_q + AW'(dst_width);
			end else begin
				i_q        <= CNT_W'(i_q + 1'b1);
				col_addr_q <= col_addr_q + AW'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			wr_valid_q <= 1'b0;
		else if (load)
			wr_valid_q <= 1'b1;
		else if (wr.ready)
			wr_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			wr_addr_q  <= col_addr_q;
			wr_color_q <= color_q;
			wr_last_q  <= emit_last;
		end
	end

	assign wr.valid         = wr_valid_q;
	assign wr.write_address = wr_addr_q;
	assign wr.write_color   = wr_color_q;
	assign wr.last_write    = wr_last_q;

	// status to the controller
	always_comb begin
		st            = '0;
		st.take       = take;
		st.on_screen  = !col_q[CW-1] && !row_q[CW-1] &&
			(col_q < CW'(src_width)) && (row_q < CW'(src_height));
		st.div_busy   = |div_busy;
		st.span_empty = (nx_q == '0) || (ny_q == '0);
		st.out_free   = out_free;
		st.emit_last  = emit_last;
	end

	// write counters stay inside the span
	`NNAS_ASSERT_SAME(a_emit_in_span, load, (i_q < nx_q) && (j_q < ny_q))
	// the last write of an item is presented with its mark set
	`NNAS_ASSERT_NEXT(a_last_marked, load && emit_last, wr.valid && wr.last_write)

endmodule

// File: rtl/nearest_neighbor_area_scaler.sv
// Nearest-neighbour area scaler. Pixels of a source area arrive in raster order on
// the pixel channel; for each on-screen pixel the block writes every destination
// pixel whose nearest source it is, up to MAX_UPSCALE per axis, as framebuffer
// writes on the wr channel, rows outer and columns inner, with last_write on the
// final one. One item is worked on at a time. An off-screen pixel ends at the check;
// an on-screen one goes on to the bit-serial span dividers and then one write per
// destination pixel, each held while the write channel stalls; the next pixel is
// taken while the last write still waits in the output register. Registers sit on
// an APB port at 4*index; the user must write them only while the block is idle,
// which the block itself does not enforce; values above MAX_DIM read as MAX_DIM.
// Depends on nnas_pkg, the channel interfaces, nnas_ctrl and nnas_dpath.
module nearest_neighbor_area_scaler #(
	parameter int MAX_DIM     = 2048,
	parameter int MAX_UPSCALE = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [nnas_pkg::PADDR_W-1:0]   paddr,
	input  logic [nnas_pkg::APB_W-1:0]     pwdata,
	output logic [nnas_pkg::APB_W-1:0]     prdata,
	output logic                           pready,
	nnas_pixel_if.sink                     pixel,
	nnas_write_if.source                   wr
);
	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam logic [DIM_W-1:0] RST_SRC_W = DIM_W'((1280 > MAX_DIM) ? MAX_DIM : 1280);
	localparam logic [DIM_W-1:0] RST_SRC_H = DIM_W'((720 > MAX_DIM) ? MAX_DIM : 720);

	logic [DIM_W-1:0] src_width_q, src_height_q, dst_width_q, dst_height_q;
	logic [nnas_pkg::CFG_W-1:0] wval;
	logic [DIM_W-1:0]           wdim;
	logic                       cfg_write;
	nnas_pkg::nnas_cfg_idx_t    cfg_idx;
	nnas_pkg::nnas_cmd_t        cmd;
	nnas_pkg::nnas_status_t     st;

	// register decode, values clamped to the largest dimension
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign cfg_idx   = nnas_pkg::nnas_cfg_idx_t'(paddr[3:2]);
	assign wval      = pwdata[nnas_pkg::CFG_W-1:0];
	assign wdim      = (32'(wval) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(wval);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= RST_SRC_W;
			src_height_q <= RST_SRC_H;
			dst_width_q  <= RST_SRC_W;
			dst_height_q <= RST_SRC_H;
		end else if (cfg_write) begin
			unique case (cfg_idx)
				nnas_pkg::CFG_SRC_WIDTH:  src_width_q  <= wdim;
				nnas_pkg::CFG_SRC_HEIGHT: src_height_q <= wdim;
				nnas_pkg::CFG_DST_WIDTH:  dst_width_q  <= wdim;
				nnas_pkg::CFG_DST_HEIGHT: dst_height_q <= wdim;
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (cfg_idx)
			nnas_pkg::CFG_SRC_WIDTH:  prdata = nnas_pkg::APB_W'(src_width_q);
			nnas_pkg::CFG_SRC_HEIGHT: prdata = nnas_pkg::APB_W'(src_height_q);
			nnas_pkg::CFG_DST_WIDTH:  prdata = nnas_pkg::APB_W'(dst_width_q);
			nnas_pkg::CFG_DST_HEIGHT: prdata = nnas_pkg::APB_W'(dst_height_q);
			default:                  prdata = '0;
		endcase
	end

	// sequencer
	nnas_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	// datapath
	nnas_dpath #(
		.MAX_UPSCALE (MAX_UPSCALE),
		.DIM_W       (DIM_W)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.src_width  (src_width_q),
		.src_height (src_height_q),
		.dst_width  (dst_width_q),
		.dst_height (dst_height_q),
		.pixel      (pixel),
		.wr         (wr)
	);

endmodule

// File: bench/nearest_neighbor_area_scaler_test.sv
// testbench of nearest_neighbor_area_scaler: raster pixels in, framebuffer writes checked
// against an in-bench prediction of the scaler; depends on nnas_pkg and the channel interfaces
module nearest_neighbor_area_scaler_test;
	import nnas_pkg::*;

	localparam int MAX_DIM        = 2048;
	localparam int MAX_UPSCALE    = 8;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 40;
	localparam int MAX_REPORTS    = 10;

	typedef struct {
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] color;
		logic               last;
	} fb_write_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [APB_W-1:0]   pwdata;
	logic [APB_W-1:0]   prdata;
	logic               pready;

	nnas_pixel_if pixel_ch ();
	nnas_write_if fb_ch ();

	// screen geometry and raster position as the scaler should hold them
	int scr_w = 1280;
	int scr_h = 720;
	int pan_w = 1280;
	int pan_h = 720;
	logic signed [COORD_W-1:0] pos_col = '0;
	logic signed [COORD_W-1:0] pos_row = '0;

	fb_write_t pending_writes[$];
	int mismatches  = 0;
	int idle_cycles = 0;
	int ready_hold  = 0;
	logic steady    = 1'b0;
	// toggled by the test sequence to ask the write side for a long hold-off
	logic hold_req  = 1'b0;
	logic hold_seen = 1'b0;

	nearest_neighbor_area_scaler #(
		.MAX_DIM     (MAX_DIM),
		.MAX_UPSCALE (MAX_UPSCALE)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pixel   (pixel_ch),
		.wr      (fb_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int clamp_dim(input logic [31:0] v);
		int u;
		u = int'(v[11:0]);
		return (u > MAX_DIM) ? MAX_DIM : u;
	endfunction

	// destination positions whose nearest source is s: [first, first + count)
	function automatic void dest_span(input int s, input int src, input int dst,
			output int first, output int count);
		longint lo, hi;
		lo = (longint'(s) * dst + src - 1) / src;
		hi = (longint'(s + 1) * dst + src - 1) / src;
		if (hi > dst)
			hi = dst;
		first = int'(lo);
		count = (hi <= lo) ? 0 : int'(hi - lo);
		if (count > MAX_UPSCALE)
			count = MAX_UPSCALE;
	endfunction

	// queue the writes one source pixel causes, then step the raster position
	function automatic void predict_writes(input logic first,
			input logic signed [COORD_W-1:0] left, input logic signed [COORD_W-1:0] top,
			input logic signed [COORD_W-1:0] right, input logic [COLOR_W-1:0] color);
		int col, row, x0, y0, nx, ny;
		longint addr;
		fb_write_t w;
		if (first) begin
			pos_col = left;
			pos_row = top;
		end
		col = int'(pos_col);
		row = int'(pos_row);
		if (scr_w != 0 && scr_h != 0 && pan_w != 0 && pan_h != 0 &&
				col >= 0 && row >= 0 && col < scr_w && row < scr_h) begin
			dest_span(col, scr_w, pan_w, x0, nx);
			dest_span(row, scr_h, pan_h, y0, ny);
			for (int j = 0; j < ny; j++) begin
				for (int i = 0; i < nx; i++) begin
					addr = longint'(y0 + j) * pan_w + x0 + i;
					w.addr = addr[ADDR_W-1:0];
					w.color = color;
					w.last = (j == ny - 1) && (i == nx - 1);
					pending_writes.push_back(w);
				end
			end
		end
		if (pos_col >= right) begin
			pos_col = left;
			pos_row = pos_row + 16'sd1;
		end else begin
			pos_col = pos_col + 16'sd1;
		end
	endfunction

	function automatic void flag_error(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch: %s", msg);
	endfunction

	// write side: check each accepted write and drive ready with random stalls
	always @(posedge clk) begin : fb_side
		fb_write_t want;
		if (fb_ch.valid && fb_ch.ready) begin
			if (pending_writes.size() == 0) begin
				flag_error($sformatf("unexpected write addr %0h color %h last %b",
					fb_ch.write_address, fb_ch.write_color, fb_ch.last_write));
			end else begin
				want = pending_writes.pop_front();
				if (fb_ch.write_address !== want.addr || fb_ch.write_color !== want.color ||
						fb_ch.last_write !== want.last)
					flag_error($sformatf("write expected %0h/%h/%b, got %0h/%h/%b",
						want.addr, want.color, want.last,
						fb_ch.write_address, fb_ch.write_color, fb_ch.last_write));
			end
		end
		if (!arst_n) begin
			fb_ch.ready <= 1'b0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			ready_hold <= HOLD_CYCLES;
			fb_ch.ready <= 1'b0;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			fb_ch.ready <= 1'b0;
		end else begin
			fb_ch.ready <= steady || ($urandom_range(99) >= 27);
		end
	end

	// watchdog on cycles with no item moving on either channel
	always @(posedge clk) begin
		if ((pixel_ch.valid && pixel_ch.ready) || (fb_ch.valid && fb_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// offer one pixel item, after an optional random gap, and wait for it to be taken
	task automatic send_pixel(input logic first, input logic signed [COORD_W-1:0] left,
			input logic signed [COORD_W-1:0] top, input logic signed [COORD_W-1:0] right,
			input logic [COLOR_W-1:0] color);
		while (!steady && $urandom_range(99) < 27) begin
			pixel_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pixel_ch.valid <= 1'b1;
		pixel_ch.first_of_area <= first;
		pixel_ch.area_left <= left;
		pixel_ch.area_top <= top;
		pixel_ch.area_right <= right;
		pixel_ch.pixel_color <= color;
		do
			@(posedge clk);
		while (!pixel_ch.ready);
		predict_writes(first, left, top, right, color);
	endtask

	// stop offering, wait for every queued write, then let the block go idle
	task automatic settle();
		pixel_ch.valid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb write: setup cycle and access cycle, then back to idle
	task automatic write_reg(input nnas_cfg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			CFG_SRC_WIDTH:  scr_w = clamp_dim(value);
			CFG_SRC_HEIGHT: scr_h = clamp_dim(value);
			CFG_DST_WIDTH:  pan_w = clamp_dim(value);
			CFG_DST_HEIGHT: pan_h = clamp_dim(value);
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_screen(input logic [31:0] sw, input logic [31:0] sh,
			input logic [31:0] dw, input logic [31:0] dh);
		settle();
		write_reg(CFG_SRC_WIDTH, sw);
		write_reg(CFG_SRC_HEIGHT, sh);
		write_reg(CFG_DST_WIDTH, dw);
		write_reg(CFG_DST_HEIGHT, dh);
	endtask

	// mostly well-formed raster areas near the screen, some noise and broken areas
	task automatic run_areas(input int n);
		int sent, w, h, r;
		logic signed [COORD_W-1:0] left, top, right, rgt;
		logic first;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(9) == 0) begin
				send_pixel(1'($urandom_range(1)), COORD_W'($urandom), COORD_W'($urandom),
					COORD_W'($urandom), $urandom);
				sent++;
			end else begin
				w = $urandom_range(1, 6);
				h = $urandom_range(1, 4);
				left = COORD_W'(int'($urandom_range(scr_w + 1)) - 2);
				top = COORD_W'(int'($urandom_range(scr_h + 1)) - 2);
				right = COORD_W'(left + w - 1);
				for (int k = 0; k < w * h && sent < n; k++) begin
					first = (k == 0);
					rgt = right;
					r = $urandom_range(24);
					if (r == 0)
						rgt = COORD_W'($urandom);
					else if (r == 1)
						first = 1'b1;
					send_pixel(first, left, top, rgt, $urandom);
					sent++;
				end
			end
		end
	endtask

	// corners, edges, wrap and malformed areas at the reset geometry
	task automatic test_reset_screen();
		send_pixel(1'b1, 16'sd0, 16'sd0, 16'sd2, 32'h0000_0000);
		send_pixel(1'b0, 16'sd0, 16'sd0, 16'sd2, 32'hFFFF_FFFF);
		send_pixel(1'b0, 16'sd0, 16'sd0, 16'sd2, $urandom);
		send_pixel(1'b0, 16'sd0, 16'sd0, 16'sd2, $urandom);
		// right and bottom edge, then past them
		repeat (5) send_pixel(pixel_ch.area_left != 16'sd1278, 16'sd1278, 16'sd719,
			16'sd1281, $urandom);
		// most negative corner, full-width row
		send_pixel(1'b1, -16'sd32768, -16'sd32768, 16'sd32767, $urandom);
		send_pixel(1'b0, -16'sd32768, -16'sd32768, 16'sd32767, $urandom);
		// right left of left: the row wraps after every pixel
		send_pixel(1'b1, 16'sd5, 16'sd3, 16'sd2, $urandom);
		send_pixel(1'b0, 16'sd5, 16'sd3, 16'sd2, $urandom);
		// row counter wraps from the top positive row to the most negative one
		send_pixel(1'b1, 16'sd0, 16'sd32767, 16'sd0, $urandom);
		send_pixel(1'b0, 16'sd0, 16'sd32767, 16'sd0, $urandom);
	endtask

	// zero registers, oversized registers, upscale past the cap, dropped pixels
	task automatic test_special_screens();
		set_screen(32'd0, 32'd720, 32'd1280, 32'd720);
		send_pixel(1'b1, 16'sd0, 16'sd0, 16'sd1, $urandom);
		send_pixel(1'b0, 16'sd0, 16'sd0, 16'sd1, $urandom);
		set_screen(32'd4, 32'd4, 32'd8, 32'd0);
		send_pixel(1'b1, 16'sd0, 16'sd0, 16'sd3, $urandom);
		// oversized values read as the largest dimension; last pixel hits the top address
		set_screen(32'h0000_0FFF, 32'hFFFF_F800, 32'h0000_1FFF, 32'd2048);
		send_pixel(1'b1, 16'sd2047, 16'sd2047, 16'sd2047, $urandom);
		set_screen(32'd2, 32'd1, 32'd40, 32'd30);
		send_pixel(1'b1, 16'sd0, 16'sd0, 16'sd1, $urandom);
		send_pixel(1'b0, 16'sd0, 16'sd0, 16'sd1, $urandom);
		set_screen(32'd10, 32'd10, 32'd3, 32'd3);
		repeat (5) send_pixel(pixel_ch.area_right != 16'sd9, 16'sd0, 16'sd0, 16'sd9, $urandom);
	endtask

	task automatic random_screen();
		int sw, sh, dw, dh;
		logic [31:0] junk;
		case ($urandom_range(3))
			0: begin
				sw = $urandom_range(1, 12);
				sh = $urandom_range(1, 12);
				dw = $urandom_range(1, 8 * sw);
				dh = $urandom_range(1, 8 * sh);
			end
			1: begin
				sw = $urandom_range(2, 40);
				sh = $urandom_range(2, 40);
				dw = $urandom_range(1, sw);
				dh = $urandom_range(1, sh);
			end
			2: begin
				sw = $urandom_range(1024, MAX_DIM);
				sh = $urandom_range(1024, MAX_DIM);
				dw = $urandom_range(1, MAX_DIM);
				dh = $urandom_range(1, MAX_DIM);
			end
			default: begin
				sw = $urandom_range(4095);
				sh = $urandom_range(4095);
				dw = $urandom_range(4095);
				dh = $urandom_range(4095);
			end
		endcase
		// junk above the register width is ignored
		junk = ($urandom_range(3) == 0) ? ($urandom & 32'hFFFF_F000) : 32'd0;
		set_screen(junk | sw, junk | sh, junk | dw, junk | dh);
	endtask

	task automatic test_random_screens();
		for (int p = 0; p < 8; p++) begin
			random_screen();
			run_areas(45);
		end
	endtask

	// a stretch with both sides always willing
	task automatic test_steady_stream();
		set_screen(32'd8, 32'd6, 32'd20, 32'd15);
		steady = 1'b1;
		run_areas(40);
		settle();
		steady = 1'b0;
	endtask

	// write side held off while pixels keep coming, then a full drain
	task automatic test_backpressure();
		set_screen(32'd4, 32'd4, 32'd32, 32'd32);
		hold_req = !hold_req;
		for (int k = 0; k < 8; k++)
			send_pixel(k == 0, 16'sd0, 16'sd0, 16'sd3, $urandom);
		settle();
		run_areas(12);
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pixel_ch.valid <= 1'b0;
		pixel_ch.first_of_area <= 1'b0;
		pixel_ch.area_left <= '0;
		pixel_ch.area_top <= '0;
		pixel_ch.area_right <= '0;
		pixel_ch.pixel_color <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_screen();
		test_special_screens();
		test_random_screens();
		test_steady_stream();
		test_backpressure();
		settle();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
